@@ sv/pdc_pkg.sv @@
`default_nettype none

package pdc_pkg;

    // register stages ahead of the output register: one operand/product stage,
    // then one stage per quotient bit of the divide path
    localparam int PDC_QBITS  = 8;
    localparam int PDC_STAGES = PDC_QBITS + 1;

    localparam logic [7:0] FULL = 8'd255;
    localparam logic [7:0] HALF = 8'd128;

    typedef logic [PDC_STAGES:1] stage_en_t;

    typedef enum logic [3:0] {
        OP_COPY      = 4'd0,
        OP_DST_ATOP  = 4'd1,
        OP_DST_IN    = 4'd2,
        OP_DST_OVER  = 4'd3,
        OP_DST_OUT   = 4'd4,
        OP_SRC_OVER  = 4'd5,
        OP_SRC_ATOP  = 4'd6,
        OP_SRC_IN    = 4'd7,
        OP_SRC_OUT   = 4'd8,
        OP_MULTIPLY  = 4'd9,
        OP_XOR       = 4'd10,
        OP_ADD       = 4'd11,
        OP_SUBTRACT  = 4'd12,
        OP_DIVIDE    = 4'd13,
        OP_SCREEN    = 4'd14,
        OP_OVERLAY   = 4'd15
    } op_t;

    function automatic logic [7:0] sat8(input logic [9:0] x);
        return (x > 10'(FULL)) ? FULL : x[7:0];
    endfunction

    // rounded x/255, saturated; x stays below 2*255*255 + 1
    function automatic logic [7:0] div255(input logic [16:0] x);
        logic [16:0] v;
        logic [16:0] w;
        v = x + 17'(HALF);
        w = v + (v >> 8);
        return sat8({1'b0, w[16:8]});
    endfunction

endpackage

`default_nettype wire

@@ sv/pdc_div.sv @@
`default_nettype none

// (dc*255)/sc, one quotient bit per stage. When dc >= sc the quotient is
// 255 or more (and sc == 0 lands here too), so only that flag is kept.
module pdc_div (
    input  wire logic                aclk,
    input  wire pdc_pkg::stage_en_t  en,
    input  wire logic [7:0]          dividend,
    input  wire logic [7:0]          divisor,
    output logic [7:0]               quot
);
    import pdc_pkg::*;

    logic [15:0] num;
    logic [7:0]  rem_reg [1:PDC_STAGES];
    logic [7:0]  low_reg [1:PDC_STAGES];
    logic [7:0]  dvs_reg [1:PDC_STAGES];
    logic [7:0]  q_reg   [1:PDC_STAGES];
    logic        sat_reg [1:PDC_STAGES];

    assign num = {dividend, 8'd0} - {8'd0, dividend};

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            rem_reg[1] <= num[15:8];
            low_reg[1] <= num[7:0];
            dvs_reg[1] <= divisor;
            q_reg[1]   <= 8'd0;
            sat_reg[1] <= (dividend >= divisor);
        end
    end

    for (genvar k = 2; k <= PDC_STAGES; k++) begin : g_step
        logic [8:0] trial;
        logic       ge;
        logic [8:0] diff;

        assign trial = {rem_reg[k-1], low_reg[k-1][7]};
        assign ge    = (trial >= {1'b0, dvs_reg[k-1]});
        assign diff  = trial - {1'b0, dvs_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= ge ? diff[7:0] : trial[7:0];
                low_reg[k] <= {low_reg[k-1][6:0], 1'b0};
                dvs_reg[k] <= dvs_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][6:0], ge};
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign quot = sat_reg[PDC_STAGES] ? FULL : q_reg[PDC_STAGES];

endmodule

`default_nettype wire

@@ sv/pdc_lane.sv @@
`default_nettype none

// One channel of the pixel. Stage 1 picks operands and multiplies,
// stage 2 scales back by 255, stage 3 combines; the result then rides a delay
// line alongside the divide path.
module pdc_lane (
    input  wire logic                aclk,
    input  wire pdc_pkg::stage_en_t  en,
    input  wire pdc_pkg::op_t        op,
    input  wire logic                alpha_mode,
    input  wire logic [7:0]          dc,
    input  wire logic [7:0]          sc,
    input  wire logic [7:0]          ad,
    input  wire logic [7:0]          as_in,
    output logic [7:0]               res
);
    import pdc_pkg::*;

    logic [7:0]  inv_ad;
    logic [7:0]  inv_as;
    logic [7:0]  inv_dc;
    logic [7:0]  inv_sc;
    logic [7:0]  a0, b0, a1, b1, a2, b2;
    logic        sum_mode;
    logic        dbl;

    logic [15:0] p0_reg, p1_reg, p2_reg;
    logic        sum_reg, dbl_reg;
    logic [7:0]  dc1_reg, sc1_reg;

    logic [16:0] x0;
    logic [7:0]  d0_reg, d1_reg, d2_reg;
    logic [7:0]  dc2_reg, sc2_reg;

    logic [7:0]  comb_res;
    logic [7:0]  arith_reg [3:PDC_STAGES];
    logic [7:0]  quot;

    assign inv_ad = FULL - ad;
    assign inv_as = FULL - as_in;
    assign inv_dc = FULL - dc;
    assign inv_sc = FULL - sc;

    always_comb begin
        a0 = 8'd0;
        b0 = 8'd0;
        a1 = 8'd0;
        b1 = 8'd0;
        a2 = 8'd0;
        b2 = 8'd0;
        sum_mode = 1'b0;
        dbl = 1'b0;
        case (op)
            OP_DST_ATOP: begin
                a0 = dc; b0 = as_in;
                a1 = sc; b1 = inv_ad;
                sum_mode = 1'b1;
            end
            OP_DST_IN: begin
                a0 = dc; b0 = as_in;
            end
            OP_DST_OVER, OP_SRC_OUT: begin
                a0 = sc; b0 = inv_ad;
            end
            OP_DST_OUT, OP_SRC_OVER: begin
                a0 = dc; b0 = inv_as;
            end
            OP_SRC_ATOP: begin
                a0 = sc; b0 = ad;
                a1 = dc; b1 = inv_as;
                sum_mode = 1'b1;
            end
            OP_SRC_IN: begin
                a0 = sc; b0 = ad;
            end
            OP_MULTIPLY: begin
                if (alpha_mode) begin
                    a0 = dc; b0 = inv_as;
                end else begin
                    a0 = sc; b0 = dc;
                    a1 = sc; b1 = inv_ad;
                    a2 = dc; b2 = inv_as;
                end
            end
            OP_XOR: begin
                a0 = sc; b0 = inv_ad;
                a1 = dc; b1 = inv_as;
                sum_mode = alpha_mode;
            end
            OP_SCREEN: begin
                if (alpha_mode) begin
                    a0 = sc; b0 = inv_ad;
                end else begin
                    a0 = inv_dc; b0 = inv_sc;
                end
            end
            OP_OVERLAY: begin
                if (alpha_mode) begin
                    a0 = sc; b0 = inv_ad;
                end else if (!dc[7]) begin
                    a0 = dc; b0 = sc;
                    dbl = 1'b1;
                end else begin
                    a0 = inv_dc; b0 = inv_sc;
                    dbl = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p0_reg  <= {8'd0, a0} * {8'd0, b0};
            p1_reg  <= {8'd0, a1} * {8'd0, b1};
            p2_reg  <= {8'd0, a2} * {8'd0, b2};
            sum_reg <= sum_mode;
            dbl_reg <= dbl;
            dc1_reg <= dc;
            sc1_reg <= sc;
        end
    end

    always_comb begin
        if (sum_reg) begin
            x0 = {1'b0, p0_reg} + {1'b0, p1_reg};
        end else if (dbl_reg) begin
            x0 = {p0_reg, 1'b0};
        end else begin
            x0 = {1'b0, p0_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            d0_reg  <= div255(x0);
            d1_reg  <= div255({1'b0, p1_reg});
            d2_reg  <= div255({1'b0, p2_reg});
            dc2_reg <= dc1_reg;
            sc2_reg <= sc1_reg;
        end
    end

    always_comb begin
        case (op)
            OP_COPY:     comb_res = sc2_reg;
            OP_DST_ATOP: comb_res = alpha_mode ? sc2_reg : d0_reg;
            OP_DST_IN, OP_DST_OUT, OP_SRC_IN, OP_SRC_OUT: comb_res = d0_reg;
            OP_DST_OVER: comb_res = sat8({2'b0, dc2_reg} + {2'b0, d0_reg});
            OP_SRC_OVER: comb_res = sat8({2'b0, sc2_reg} + {2'b0, d0_reg});
            OP_SRC_ATOP: comb_res = alpha_mode ? dc2_reg : d0_reg;
            OP_MULTIPLY: begin
                if (alpha_mode) begin
                    comb_res = sat8({2'b0, sc2_reg} + {2'b0, d0_reg});
                end else begin
                    comb_res = sat8({2'b0, d0_reg} + {2'b0, d1_reg} + {2'b0, d2_reg});
                end
            end
            OP_XOR: begin
                comb_res = alpha_mode ? d0_reg : sat8({2'b0, d0_reg} + {2'b0, d1_reg});
            end
            OP_ADD:      comb_res = sat8({2'b0, dc2_reg} + {2'b0, sc2_reg});
            OP_SUBTRACT: comb_res = (dc2_reg > sc2_reg) ? (dc2_reg - sc2_reg) : 8'd0;
            OP_DIVIDE:   comb_res = dc2_reg;
            OP_SCREEN: begin
                if (alpha_mode) begin
                    comb_res = sat8({2'b0, dc2_reg} + {2'b0, d0_reg});
                end else begin
                    comb_res = FULL - d0_reg;
                end
            end
            OP_OVERLAY: begin
                if (alpha_mode) begin
                    comb_res = sat8({2'b0, dc2_reg} + {2'b0, d0_reg});
                end else if (!dc2_reg[7]) begin
                    comb_res = d0_reg;
                end else begin
                    comb_res = FULL - d0_reg;
                end
            end
            default: comb_res = sc2_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            arith_reg[3] <= comb_res;
        end
    end

    for (genvar k = 4; k <= PDC_STAGES; k++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                arith_reg[k] <= arith_reg[k-1];
            end
        end
    end

    pdc_div u_div (
        .aclk     (aclk),
        .en       (en),
        .dividend (dc),
        .divisor  (sc),
        .quot     (quot)
    );

    assign res = (op == OP_DIVIDE && !alpha_mode) ? quot : arith_reg[PDC_STAGES];

endmodule

`default_nettype wire

@@ sv/porter_duff_rgba_compositor.sv @@
// Pipeline: 9 lane stages, set by the one-bit-per-stage divide path, then the
//   output register.
// Throughput: one pixel per clock while the output side accepts; stages with no
//   beat in them close up while the output side stalls.
// Reset (aresetn low, synchronous): pipeline and output emptied, operator
//   register back to copy source.
`default_nettype none

module porter_duff_rgba_compositor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_dst_red,
    input  wire logic [7:0]  s_dst_green,
    input  wire logic [7:0]  s_dst_blue,
    input  wire logic [7:0]  s_dst_alpha,
    input  wire logic [7:0]  s_src_red,
    input  wire logic [7:0]  s_src_green,
    input  wire logic [7:0]  s_src_blue,
    input  wire logic [7:0]  s_src_alpha,
    input  wire logic        s_frame_end_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_red,
    output logic [7:0]       m_out_green,
    output logic [7:0]       m_out_blue,
    output logic [7:0]       m_out_alpha,
    output logic             m_frame_end_out
);
    import pdc_pkg::*;

    op_t               op_reg;
    logic [PDC_STAGES:1] v_reg;
    logic [PDC_STAGES:1] v_next;
    stage_en_t         take;
    logic              take_out;
    logic              fe_reg [1:PDC_STAGES];
    logic [7:0]        dst [4];
    logic [7:0]        src [4];
    logic [7:0]        lane_res [4];

    logic              m_valid_reg;
    logic [7:0]        red_reg, green_reg, blue_reg, alpha_reg;
    logic              fe_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_COPY;
        end else if (cfg_wr_en) begin
            op_reg <= op_t'(cfg_wr_data);
        end
    end

    // a stage loads when it is empty or its beat moves on this cycle
    assign take_out = !m_valid_reg || m_ready;

    always_comb begin
        take[PDC_STAGES] = !v_reg[PDC_STAGES] || take_out;
        for (int k = PDC_STAGES - 1; k >= 1; k--) begin
            take[k] = !v_reg[k] || take[k+1];
        end
    end

    assign s_ready = take[1];

    always_comb begin
        v_next = v_reg;
        if (take[1]) begin
            v_next[1] = s_valid;
        end
        for (int k = 2; k <= PDC_STAGES; k++) begin
            if (take[k]) begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take[1]) begin
            fe_reg[1] <= s_frame_end_in;
        end
    end

    for (genvar k = 2; k <= PDC_STAGES; k++) begin : g_fe
        always_ff @(posedge aclk) begin
            if (take[k]) begin
                fe_reg[k] <= fe_reg[k-1];
            end
        end
    end

    assign dst[0] = s_dst_red;
    assign dst[1] = s_dst_green;
    assign dst[2] = s_dst_blue;
    assign dst[3] = s_dst_alpha;
    assign src[0] = s_src_red;
    assign src[1] = s_src_green;
    assign src[2] = s_src_blue;
    assign src[3] = s_src_alpha;

    for (genvar i = 0; i < 4; i++) begin : g_lane
        pdc_lane u_lane (
            .aclk       (aclk),
            .en         (take),
            .op         (op_reg),
            .alpha_mode (i == 3),
            .dc         (dst[i]),
            .sc         (src[i]),
            .ad         (s_dst_alpha),
            .as_in      (s_src_alpha),
            .res        (lane_res[i])
        );
    end

    // merge the four lanes into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take_out) begin
            m_valid_reg <= v_reg[PDC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (take_out) begin
            red_reg    <= lane_res[0];
            green_reg  <= lane_res[1];
            blue_reg   <= lane_res[2];
            alpha_reg  <= lane_res[3];
            fe_out_reg <= fe_reg[PDC_STAGES];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_red       = red_reg;
    assign m_out_green     = green_reg;
    assign m_out_blue      = blue_reg;
    assign m_out_alpha     = alpha_reg;
    assign m_frame_end_out = fe_out_reg;

endmodule

`default_nettype wire

@@ sv/pdc_checker.sv @@
`default_nettype none

module pdc_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_ready,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_out_red,
    input  wire logic [7:0]  m_out_green,
    input  wire logic [7:0]  m_out_blue,
    input  wire logic [7:0]  m_out_alpha,
    input  wire logic        m_frame_end_out
);

    // reset leaves nothing to deliver
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output beat right after reset");

    // an empty output register means every stage can move
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a draining sink never backs up the input
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_red) && $stable(m_out_green)
            && $stable(m_out_blue) && $stable(m_out_alpha)
            && $stable(m_frame_end_out))
        else $error("output beat changed while stalled");

endmodule

bind porter_duff_rgba_compositor pdc_checker u_pdc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_red       (m_out_red),
    .m_out_green     (m_out_green),
    .m_out_blue      (m_out_blue),
    .m_out_alpha     (m_out_alpha),
    .m_frame_end_out (m_frame_end_out)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import pdc_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int PIPE_LATENCY    = 10;
    localparam int PIXELS_PER_RUN  = 80;
    localparam int RANDOM_RUNS     = 20;
    localparam int SINK_HOLD       = 120;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_PRINTED     = 30;
    localparam int MAXV            = 255;
    localparam int MID             = 128;

    // channel index 0..3 = red, green, blue, alpha
    typedef struct packed {
        logic [3:0][7:0] dst;
        logic [3:0][7:0] src;
        logic            frame_end;
    } pixel_pair_t;

    typedef struct packed {
        logic [3:0][7:0] rgba;
        logic            frame_end;
    } pixel_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_dst_red = '0;
    logic [7:0] s_dst_green = '0;
    logic [7:0] s_dst_blue = '0;
    logic [7:0] s_dst_alpha = '0;
    logic [7:0] s_src_red = '0;
    logic [7:0] s_src_green = '0;
    logic [7:0] s_src_blue = '0;
    logic [7:0] s_src_alpha = '0;
    logic       s_frame_end_in = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_red;
    logic [7:0] m_out_green;
    logic [7:0] m_out_blue;
    logic [7:0] m_out_alpha;
    logic       m_frame_end_out;

    pixel_pair_t pending_pixels[$];
    pixel_t      expected_pixels[$];
    pixel_pair_t offered_pixel;
    op_t         blend_op = OP_COPY;
    int          idle_pct = 0;
    int          src_gap = 0;
    int          sink_stall = 0;
    int          sink_hold = 0;
    int          results_seen = 0;
    int          quiet_cycles = 0;
    int          error_count = 0;

    porter_duff_rgba_compositor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_dst_red       (s_dst_red),
        .s_dst_green     (s_dst_green),
        .s_dst_blue      (s_dst_blue),
        .s_dst_alpha     (s_dst_alpha),
        .s_src_red       (s_src_red),
        .s_src_green     (s_src_green),
        .s_src_blue      (s_src_blue),
        .s_src_alpha     (s_src_alpha),
        .s_frame_end_in  (s_frame_end_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_red       (m_out_red),
        .m_out_green     (m_out_green),
        .m_out_blue      (m_out_blue),
        .m_out_alpha     (m_out_alpha),
        .m_frame_end_out (m_frame_end_out)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int clamp255(input int x);
        return (x > MAXV) ? MAXV : x;
    endfunction

    // rounded x/255
    function automatic int scale255(input int x);
        int v;
        v = x + MID;
        return clamp255((v + (v >> 8)) >> 8);
    endfunction

    function automatic pixel_t composite(input op_t op, input pixel_pair_t p);
        pixel_t r;
        int k, dc, sc, ad, sa, ia, is, v;
        ad = p.dst[3];
        sa = p.src[3];
        ia = MAXV - ad;
        is = MAXV - sa;
        for (k = 0; k < 4; k++) begin
            dc = p.dst[k];
            sc = p.src[k];
            case (op)
                OP_COPY:     v = sc;
                OP_DST_ATOP: v = (k == 3) ? sa : scale255(dc * sa + sc * ia);
                OP_DST_IN:   v = scale255(dc * sa);
                OP_DST_OVER: v = clamp255(dc + scale255(sc * ia));
                OP_DST_OUT:  v = scale255(dc * is);
                OP_SRC_OVER: v = clamp255(sc + scale255(dc * is));
                OP_SRC_ATOP: v = (k == 3) ? ad : scale255(sc * ad + dc * is);
                OP_SRC_IN:   v = scale255(sc * ad);
                OP_SRC_OUT:  v = scale255(sc * ia);
                OP_MULTIPLY: begin
                    if (k == 3)
                        v = clamp255(sa + scale255(ad * is));
                    else
                        v = clamp255(scale255(sc * dc) + scale255(sc * ia) + scale255(dc * is));
                end
                OP_XOR: begin
                    if (k == 3)
                        v = scale255(sa * ia + ad * is);
                    else
                        v = clamp255(scale255(sc * ia) + scale255(dc * is));
                end
                OP_ADD:      v = clamp255(dc + sc);
                OP_SUBTRACT: v = (dc > sc) ? dc - sc : 0;
                OP_DIVIDE: begin
                    if (k == 3)
                        v = ad;
                    else
                        v = (sc == 0) ? MAXV : clamp255(dc * MAXV / sc);
                end
                OP_SCREEN: begin
                    if (k == 3)
                        v = clamp255(ad + scale255(sa * ia));
                    else
                        v = MAXV - scale255((MAXV - dc) * (MAXV - sc));
                end
                OP_OVERLAY: begin
                    if (k == 3)
                        v = clamp255(ad + scale255(sa * ia));
                    else if (dc < MID)
                        v = scale255(2 * dc * sc);
                    else
                        v = MAXV - scale255(2 * (MAXV - dc) * (MAXV - sc));
                end
                default:     v = 0;
            endcase
            r.rgba[k] = v[7:0];
        end
        r.frame_end = p.frame_end;
        return r;
    endfunction

    // fields are written alpha first: {a, b, g, r}
    function automatic pixel_pair_t special_pixel(input int which, input logic fe);
        pixel_pair_t p;
        case (which)
            0: begin  // opaque source over empty destination
                p.dst = {8'd0, 8'd0, 8'd0, 8'd0};
                p.src = {8'd255, 8'd255, 8'd255, 8'd255};
            end
            1: begin  // zero source: divide by zero, full subtract
                p.dst = {8'd255, 8'd255, 8'd255, 8'd255};
                p.src = {8'd0, 8'd0, 8'd0, 8'd0};
            end
            2: begin  // colors far above alpha, sums overflow
                p.dst = {8'd10, 8'd230, 8'd240, 8'd250};
                p.src = {8'd20, 8'd255, 8'd200, 8'd245};
            end
            3: begin  // overlay branch boundary 127/128
                p.dst = {8'd200, 8'd0, 8'd128, 8'd127};
                p.src = {8'd100, 8'd255, 8'd200, 8'd200};
            end
            4: begin  // subtract below zero, large quotients
                p.dst = {8'd60, 8'd100, 8'd255, 8'd10};
                p.src = {8'd90, 8'd100, 8'd1, 8'd200};
            end
            default: begin  // mixed zero divisors
                p.dst = {8'd255, 8'd1, 8'd0, 8'd200};
                p.src = {8'd0, 8'd255, 8'd1, 8'd0};
            end
        endcase
        p.frame_end = fe;
        return p;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(127, 128));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        // keep the log short when things go badly wrong
        if (error_count <= MAX_PRINTED)
            $display("result %0d (op %0d): %s got %0d want %0d",
                     results_seen, blend_op, what, got, want);
    endtask

    task automatic program_operator(input op_t op);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= op;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        blend_op = op;
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_pixels.push_back(composite(blend_op, offered_pixel));
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_pixels.size() != 0 && idle_pct != 0 &&
                             $urandom_range(0, 99) < idle_pct) begin
                    src_gap = $urandom_range(0, 13);
                    s_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    offered_pixel = pending_pixels.pop_front();
                    s_dst_red      <= offered_pixel.dst[0];
                    s_dst_green    <= offered_pixel.dst[1];
                    s_dst_blue     <= offered_pixel.dst[2];
                    s_dst_alpha    <= offered_pixel.dst[3];
                    s_src_red      <= offered_pixel.src[0];
                    s_src_green    <= offered_pixel.src[1];
                    s_src_blue     <= offered_pixel.src[2];
                    s_src_alpha    <= offered_pixel.src[3];
                    s_frame_end_in <= offered_pixel.frame_end;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        pixel_t got, want;
        int k;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.rgba      = {m_out_alpha, m_out_blue, m_out_green, m_out_red};
                got.frame_end = m_frame_end_out;
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected beat, red", got.rgba[0], -1);
                end else begin
                    want = expected_pixels.pop_front();
                    for (k = 0; k < 4; k++)
                        if (got.rgba[k] !== want.rgba[k])
                            report_mismatch(k == 0 ? "red" : k == 1 ? "green" :
                                            k == 2 ? "blue" : "alpha",
                                            got.rgba[k], want.rgba[k]);
                    if (got.frame_end !== want.frame_end)
                        report_mismatch("frame_end", got.frame_end, want.frame_end);
                end
                results_seen++;
                // long back-pressure mid-run so the pipeline fills and s_ready drops
                if (results_seen % 400 == 300)
                    sink_hold = SINK_HOLD;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_ready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                sink_stall = $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int op_order[16];
        int i, j, n, t, tmp;
        bit premul;
        pixel_pair_t p;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every operator once, plus its corner vectors where they matter
        idle_pct = 15;
        for (i = 0; i < 16; i++) begin
            program_operator(op_t'(i));
            pending_pixels.push_back(special_pixel(i % 4, i[0]));
            case (op_t'(i))
                OP_ADD:      pending_pixels.push_back(special_pixel(2, 1'b1));
                OP_SUBTRACT: pending_pixels.push_back(special_pixel(4, 1'b0));
                OP_DIVIDE:   pending_pixels.push_back(special_pixel(5, 1'b1));
                OP_OVERLAY:  pending_pixels.push_back(special_pixel(3, 1'b0));
                default:     ;
            endcase
            wait_idle();
        end

        for (i = 0; i < 16; i++)
            op_order[i] = i;
        for (i = 15; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = op_order[i];
            op_order[i] = op_order[j];
            op_order[j] = tmp;
        end

        for (t = 0; t < RANDOM_RUNS; t++) begin
            program_operator(op_t'((t < 16) ? op_order[t] : $urandom_range(0, 15)));
            if (t == RANDOM_RUNS - 1)
                idle_pct = 0;
            else
                idle_pct = (t % 3 == 0) ? 0 : (t % 3 == 1) ? 8 : 25;
            for (n = 0; n < PIXELS_PER_RUN; n++) begin
                p.dst[3] = pick_byte();
                p.src[3] = pick_byte();
                // mostly premultiplied pixels, some raw ones that overflow
                premul = ($urandom_range(0, 9) < 6);
                for (j = 0; j < 3; j++) begin
                    p.dst[j] = premul ? 8'($urandom_range(0, p.dst[3])) : pick_byte();
                    p.src[j] = premul ? 8'($urandom_range(0, p.src[3])) : pick_byte();
                end
                p.frame_end = ($urandom_range(0, 15) == 0);
                pending_pixels.push_back(p);
            end
            wait_idle();
        end

        repeat (PIPE_LATENCY + 4) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/pdc_pkg.sv
sv/pdc_div.sv
sv/pdc_lane.sv
sv/porter_duff_rgba_compositor.sv
sv/pdc_checker.sv
tb/testbench.sv
